[rtl/assert_macros.svh]
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define ECOV_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// plain condition that must hold at every clock edge outside reset
`define ECOV_CHECK(label, clk, rst_n, cond, msg) \
  `ECOV_ASSERT(label, clk, rst_n, cond, msg)
`endif

[rtl/ecov_pkg.sv]
// shared types and constants of the exponential covariance kernel
`default_nettype none
package ecov_pkg;
  localparam int unsigned SumW   = 40;
  localparam int unsigned CoordW = 16;
  localparam int unsigned CfgW   = 24;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned QDepth = 2;

  localparam logic [IdxW-1:0] REG_INV_LEN_SQ = 2'd0;
  localparam logic [IdxW-1:0] REG_VARIANCE   = 2'd1;

  localparam logic [31:0] EXP_NEG_ONE_Q32 = 32'd1580030169;
  localparam logic [31:0] DIST_CUTOFF     = 32'h0011_0000;
  localparam logic [3:0]  SERIES_TERMS    = 4'd13;

  // request moved from the accumulator into the queue
  typedef struct packed {
    logic            valid;
    logic [SumW-1:0] sum;
  } ecov_req_t;
endpackage
`default_nettype wire

[rtl/exponential_covariance_kernel.sv]
// top level of the exponential covariance kernel
// Coordinate pairs are taken one per cycle while full is low; the front end
// keeps the saturating sum of squared differences and, on the last coordinate,
// hands it to a two-entry queue. The back end works on one pair at a time:
// the scaling product in a low and a high half, a bit-serial square root, one
// check, then 13 series terms (each one multiply plus a bit-serial divide by
// the term index), one multiply per integer unit of distance (up to 16), the
// variance product and the load of the result. A distance of 17 or more skips
// the series and gives zero. The back end reads the configuration registers
// while it runs, so write them only while no pair is in flight.
`default_nettype none
module exponential_covariance_kernel (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic signed [ecov_pkg::CoordW-1:0] coord_a_i,
  input  wire logic signed [ecov_pkg::CoordW-1:0] coord_b_i,
  input  wire logic                               last_coord_i,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic [ecov_pkg::CfgW-1:0]               covariance_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [ecov_pkg::IdxW-1:0]          cfg_idx_i,
  input  wire logic [ecov_pkg::CfgW-1:0]          cfg_wdata_i
);
  logic [ecov_pkg::CfgW-1:0] inv_len_q, var_q;
  ecov_pkg::ecov_req_t       req;
  logic                      q_full, q_valid, q_pop, res_valid;
  logic [ecov_pkg::SumW-1:0] q_sum;
  logic                      accept;

  assign accept = push && !q_full;
  assign full   = q_full;
  assign empty  = !res_valid;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_len_q <= 24'h01_0000;
      var_q     <= 24'h01_0000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ecov_pkg::REG_INV_LEN_SQ: inv_len_q <= cfg_wdata_i;
        ecov_pkg::REG_VARIANCE:   var_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ecov_front u_front (
    .clk_i, .rst_ni,
    .accept_i     (accept),
    .coord_a_i, .coord_b_i, .last_coord_i,
    .req_o        (req)
  );

  ecov_queue u_queue (
    .clk_i, .rst_ni,
    .req_i   (req),
    .full_o  (q_full),
    .valid_o (q_valid),
    .sum_o   (q_sum),
    .pop_i   (q_pop)
  );

  ecov_back u_back (
    .clk_i, .rst_ni,
    .req_valid_i     (q_valid),
    .req_sum_i       (q_sum),
    .req_pop_o       (q_pop),
    .inv_length_sq_i (inv_len_q),
    .variance_i      (var_q),
    .res_valid_o     (res_valid),
    .res_data_o      (covariance_o),
    .res_pop_i       (pop)
  );
endmodule
`default_nettype wire

[rtl/ecov_front.sv]
// front end: accumulates squared coordinate differences per pair
`default_nettype none
module ecov_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             accept_i,
  input  wire logic signed [ecov_pkg::CoordW-1:0] coord_a_i,
  input  wire logic signed [ecov_pkg::CoordW-1:0] coord_b_i,
  input  wire logic                             last_coord_i,
  output ecov_pkg::ecov_req_t                   req_o
);
  logic [ecov_pkg::SumW-1:0] sum_q, sum_d;
  logic signed [ecov_pkg::CoordW:0] diff;
  logic [ecov_pkg::CoordW:0]        mag;
  logic [2*ecov_pkg::CoordW+1:0]    sq;
  logic [ecov_pkg::SumW:0]          total;
  logic [ecov_pkg::SumW-1:0]        sat;

  // exact difference, square and saturating sum
  always_comb begin
    diff  = (ecov_pkg::CoordW+1)'(coord_a_i) - (ecov_pkg::CoordW+1)'(coord_b_i);
    mag   = diff[ecov_pkg::CoordW] ? (ecov_pkg::CoordW+1)'(-diff) : diff;
    sq    = (2*ecov_pkg::CoordW+2)'(mag) * (2*ecov_pkg::CoordW+2)'(mag);
    total = {1'b0, sum_q} + (ecov_pkg::SumW+1)'(sq);
    sat   = total[ecov_pkg::SumW] ? '1 : total[ecov_pkg::SumW-1:0];
    sum_d = sum_q;
    if (accept_i) begin
      sum_d = last_coord_i ? '0 : sat;
    end
    req_o.valid = accept_i && last_coord_i;
    req_o.sum   = sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end
endmodule
`default_nettype wire

[rtl/ecov_queue.sv]
// short queue of finished sums between front and back end
`default_nettype none
module ecov_queue (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  ecov_pkg::ecov_req_t            req_i,
  output logic                           full_o,
  output logic                           valid_o,
  output logic [ecov_pkg::SumW-1:0]      sum_o,
  input  wire logic                      pop_i
);
  logic [ecov_pkg::SumW-1:0] mem_q [ecov_pkg::QDepth];
  logic wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic do_pop;

  assign full_o  = (cnt_q == 2'(ecov_pkg::QDepth));
  assign valid_o = (cnt_q != 2'd0);
  assign sum_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      mem_q[wr_ptr_q] <= req_i.sum;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (req_i.valid) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)      rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(req_i.valid) - 2'(do_pop);
    end
  end
endmodule
`default_nettype wire

[rtl/ecov_back.sv]
// back end: scaling, square root, exponential and variance product
`default_nettype none
module ecov_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      req_valid_i,
  input  wire logic [ecov_pkg::SumW-1:0] req_sum_i,
  output logic                           req_pop_o,
  input  wire logic [ecov_pkg::CfgW-1:0] inv_length_sq_i,
  input  wire logic [ecov_pkg::CfgW-1:0] variance_i,
  output logic                           res_valid_o,
  output logic [ecov_pkg::CfgW-1:0]      res_data_o,
  input  wire logic                      res_pop_i
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MLO  = 4'd1;
  localparam logic [3:0] S_MHI  = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_TMUL = 4'd5;
  localparam logic [3:0] S_TDIV = 4'd6;
  localparam logic [3:0] S_NMUL = 4'd7;
  localparam logic [3:0] S_VMUL = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]  state_q;
  logic [39:0] sum_q;
  logic [43:0] acc_q;
  logic [63:0] num_q, res_q;
  logic [4:0]  it_q;
  logic [4:0]  n_q;
  logic [31:0] f_q;
  logic [32:0] e_q, term_q, dx_q;
  logic [3:0]  k_q, rem_q;
  logic [5:0]  dcnt_q;
  logic [23:0] cov_q, out_q;
  logic        out_valid_q;

  logic [63:0] bitv, trial;
  logic [43:0] hi_prod;
  logic [64:0] tprod, nprod;
  logic [56:0] vprod;
  logic [4:0]  tr, tr_sub;
  logic        ge;
  logic [32:0] quot;

  // datapath terms of the current step
  always_comb begin
    bitv    = 64'd1 << {it_q, 1'b0};
    trial   = res_q + bitv;
    hi_prod = 44'(sum_q[39:20]) * 44'(inv_length_sq_i);
    tprod   = 65'(term_q) * 65'(f_q);
    nprod   = 65'(e_q) * 65'(ecov_pkg::EXP_NEG_ONE_Q32);
    vprod   = 57'(variance_i) * 57'(e_q);
    tr      = {rem_q, dx_q[32]};
    ge      = (tr >= {1'b0, k_q});
    tr_sub  = tr - {1'b0, k_q};
    quot    = {dx_q[31:0], ge};
  end

  assign req_pop_o   = (state_q == S_IDLE) && req_valid_i;
  assign res_valid_o = out_valid_q;
  assign res_data_o  = out_q;

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: sum_q <= req_sum_i;
      S_MLO:  acc_q <= 44'(sum_q[19:0]) * 44'(inv_length_sq_i);
      S_MHI: begin
        num_q <= 64'(acc_q) + (64'(hi_prod) << 20);
        res_q <= '0;
      end
      S_SQRT: begin
        if (num_q >= trial) begin
          num_q <= num_q - trial;
          res_q <= (res_q >> 1) + bitv;
        end else begin
          res_q <= res_q >> 1;
        end
      end
      S_CHK: begin
        cov_q  <= '0;
        n_q    <= res_q[20:16];
        f_q    <= {res_q[15:0], 16'h0};
        e_q    <= 33'h1_0000_0000;
        term_q <= 33'h1_0000_0000;
      end
      S_TMUL: begin
        dx_q  <= tprod[64:32];
        rem_q <= '0;
      end
      S_TDIV: begin
        rem_q <= ge ? tr_sub[3:0] : tr[3:0];
        dx_q  <= quot;
        if (dcnt_q == 6'd0) begin
          term_q <= quot;
          e_q    <= k_q[0] ? e_q - quot : e_q + quot;
        end
      end
      S_NMUL: begin
        if (n_q != 5'd0) begin
          e_q <= nprod[64:32];
          n_q <= n_q - 5'd1;
        end
      end
      S_VMUL: cov_q <= vprod[55:32];
      // load only once the previous result has been taken
      S_DONE: begin
        if (!out_valid_q) begin
          out_q <= cov_q;
        end
      end
      default: ;
    endcase
  end

  // sequencer and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      it_q        <= '0;
      k_q         <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (res_pop_i && out_valid_q) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (req_valid_i) state_q <= S_MLO;
        S_MLO:  state_q <= S_MHI;
        S_MHI: begin
          it_q    <= 5'd31;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          it_q <= it_q - 5'd1;
          if (it_q == 5'd0) state_q <= S_CHK;
        end
        S_CHK: begin
          k_q     <= 4'd1;
          state_q <= (res_q[31:0] >= ecov_pkg::DIST_CUTOFF) ? S_DONE : S_TMUL;
        end
        S_TMUL: begin
          dcnt_q  <= 6'd32;
          state_q <= S_TDIV;
        end
        S_TDIV: begin
          dcnt_q <= dcnt_q - 6'd1;
          if (dcnt_q == 6'd0) begin
            k_q     <= k_q + 4'd1;
            state_q <= (k_q == ecov_pkg::SERIES_TERMS) ? S_NMUL : S_TMUL;
          end
        end
        S_NMUL: if (n_q == 5'd0) state_q <= S_VMUL;
        S_VMUL: state_q <= S_DONE;
        S_DONE: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/ecov_checker.sv]
// port-level checker for the exponential covariance kernel, with its bind
`default_nettype none
`include "assert_macros.svh"
module ecov_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        push,
  input wire logic        full,
  input wire logic        last_coord_i,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [23:0] covariance_o
);
  logic [3:0] pend_q;
  logic       in_last, out_req;

  assign in_last = push && !full && last_coord_i;
  assign out_req = pop && !empty;

  // pairs closed but not yet read out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 4'(in_last) - 4'(out_req);
    end
  end

  `ECOV_ASSERT(a_hold, clk_i, rst_ni, !empty && !pop |=> !empty && $stable(covariance_o), "result dropped or changed while waiting")
  `ECOV_CHECK(a_no_phantom, clk_i, rst_ni, empty || pend_q != 4'd0, "result without a closed pair")
  `ECOV_CHECK(a_full_count, clk_i, rst_ni, !full || pend_q >= 4'd2, "full with too few pairs pending")
  `ECOV_CHECK(a_bound, clk_i, rst_ni, pend_q <= 4'd4, "more pairs pending than the block holds")
endmodule

bind exponential_covariance_kernel ecov_checker u_ecov_checker (.*);
`default_nettype wire
